// ===== hw/rtl/triangle_tile_coverage_core_assert.svh =====
`ifndef TRIANGLE_TILE_COVERAGE_CORE_ASSERT_SVH
`define TRIANGLE_TILE_COVERAGE_CORE_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define TTC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a condition at one edge implies another at the next edge.
`define TTC_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/ttc_pkg.sv =====
`timescale 1ns / 1ps

package ttc_pkg;

	// Fixed field widths.
	localparam int COORD_W  = 16;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int TILE_W   = 8;
	localparam int CHAN_W   = 8;
	localparam int COLOR_W  = 3 * CHAN_W;
	localparam int BASE_W   = 22;
	localparam int CFG_W    = 12;
	localparam int SCREEN_W = 13;
	localparam int CFG_IDX_W = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

	// Register reset values.
	localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH  = CFG_W'(640);
	localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT = CFG_W'(480);

	// Load enables of the pipeline stages.
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
	} pipe_ctrl_t;

	// Width of a pixel coordinate inside the addressable tile range.
	function automatic int pix_w(input int tile_side);
		return TILE_W + $clog2(tile_side);
	endfunction

	// Width of a signed distance from a vertex to a pixel center.
	function automatic int dist_w(input int pxw, input int frac_bits);
		return ((pxw + frac_bits + 1 > COORD_W) ? pxw + frac_bits + 1 : COORD_W) + 1;
	endfunction

	// Width of an edge function value with room for the in-tile steps.
	function automatic int edge_w(input int dw);
		return dw + DIFF_W + 3 + TILE_W;
	endfunction

endpackage

// ===== hw/rtl/ttc_setup.sv =====
`timescale 1ns / 1ps

module ttc_setup #(
	parameter int TILE_SIDE = 8,
	parameter int FRAC_BITS = 4,
	localparam int PXW = ttc_pkg::pix_w(TILE_SIDE),
	localparam int DW  = ttc_pkg::dist_w(PXW, FRAC_BITS),
	localparam int EW  = ttc_pkg::edge_w(DW)
) (
	input  logic                                 clk,
	input  ttc_pkg::pipe_ctrl_t                  ctrl,
	input  logic signed [ttc_pkg::COORD_W-1:0]   v0_x,
	input  logic signed [ttc_pkg::COORD_W-1:0]   v0_y,
	input  logic signed [ttc_pkg::COORD_W-1:0]   v1_x,
	input  logic signed [ttc_pkg::COORD_W-1:0]   v1_y,
	input  logic signed [ttc_pkg::COORD_W-1:0]   v2_x,
	input  logic signed [ttc_pkg::COORD_W-1:0]   v2_y,
	input  logic [ttc_pkg::TILE_W-1:0]           tile_col,
	input  logic [ttc_pkg::TILE_W-1:0]           tile_row,
	input  logic [ttc_pkg::CHAN_W-1:0]           color_red,
	input  logic [ttc_pkg::CHAN_W-1:0]           color_green,
	input  logic [ttc_pkg::CHAN_W-1:0]           color_blue,
	input  logic [ttc_pkg::SCREEN_W-1:0]         w_eff,
	output logic signed [EW-1:0]                 e0_s3 [3],
	output logic signed [ttc_pkg::DIFF_W-1:0]    dx_s3 [3],
	output logic signed [ttc_pkg::DIFF_W-1:0]    dy_s3 [3],
	output logic [PXW-1:0]                       px0_s3,
	output logic [PXW-1:0]                       py0_s3,
	output logic [ttc_pkg::BASE_W-1:0]           base_s3,
	output logic [ttc_pkg::COLOR_W-1:0]          color_s3
);

	localparam int HALF = 1 << (FRAC_BITS - 1);
	localparam int PW   = DW + ttc_pkg::DIFF_W;
	localparam int BW   = (PXW + ttc_pkg::SCREEN_W + 1 > ttc_pkg::BASE_W) ?
		PXW + ttc_pkg::SCREEN_W + 1 : ttc_pkg::BASE_W;

	logic [PXW-1:0]                        px0, py0;
	logic [PXW+FRAC_BITS-1:0]              cx0, cy0;
	logic signed [ttc_pkg::COORD_W-1:0]    ax [3];
	logic signed [ttc_pkg::COORD_W-1:0]    ay [3];
	logic signed [ttc_pkg::COORD_W-1:0]    bx [3];
	logic signed [ttc_pkg::COORD_W-1:0]    by [3];

	logic signed [DW-1:0]                  qx_s1 [3];
	logic signed [DW-1:0]                  qy_s1 [3];
	logic signed [ttc_pkg::DIFF_W-1:0]     dx_s1 [3];
	logic signed [ttc_pkg::DIFF_W-1:0]     dy_s1 [3];
	logic [PXW-1:0]                        px0_s1, py0_s1;
	logic [ttc_pkg::COLOR_W-1:0]           color_s1;

	logic signed [PW-1:0]                  p1_s2 [3];
	logic signed [PW-1:0]                  p2_s2 [3];
	logic signed [ttc_pkg::DIFF_W-1:0]     dx_s2 [3];
	logic signed [ttc_pkg::DIFF_W-1:0]     dy_s2 [3];
	logic [PXW-1:0]                        px0_s2, py0_s2;
	logic [ttc_pkg::BASE_W-1:0]            base_s2;
	logic [ttc_pkg::COLOR_W-1:0]           color_s2;
	logic [BW-1:0]                         base_full;

	// Tile origin in pixels and its first pixel center in fixed point.
	assign px0 = PXW'(tile_col) * PXW'(TILE_SIDE);
	assign py0 = PXW'(tile_row) * PXW'(TILE_SIDE);
	assign cx0 = {px0, FRAC_BITS'(HALF)};
	assign cy0 = {py0, FRAC_BITS'(HALF)};

	// Edge endpoints: edge 0 runs v1 to v2, edge 1 v2 to v0, edge 2 v0 to v1.
	assign ax[0] = v1_x;
	assign ay[0] = v1_y;
	assign bx[0] = v2_x;
	assign by[0] = v2_y;
	assign ax[1] = v2_x;
	assign ay[1] = v2_y;
	assign bx[1] = v0_x;
	assign by[1] = v0_y;
	assign ax[2] = v0_x;
	assign ay[2] = v0_y;
	assign bx[2] = v1_x;
	assign by[2] = v1_y;

	// Stage 1: offsets of the first center from each edge start, and edge deltas.
	always_ff @(posedge clk) begin
		if (ctrl.ld_s1) begin
			for (int e = 0; e < 3; e++) begin
				qx_s1[e] <= $signed(DW'(cx0)) - DW'(ax[e]);
				qy_s1[e] <= $signed(DW'(cy0)) - DW'(ay[e]);
				dx_s1[e] <= ttc_pkg::DIFF_W'(bx[e]) - ttc_pkg::DIFF_W'(ax[e]);
				dy_s1[e] <= ttc_pkg::DIFF_W'(by[e]) - ttc_pkg::DIFF_W'(ay[e]);
			end
			px0_s1   <= px0;
			py0_s1   <= py0;
			color_s1 <= {color_red, color_green, color_blue};
		end
	end

	// Row stride product for the framebuffer index of the tile origin.
	assign base_full = BW'(py0_s1) * BW'(w_eff) + BW'(px0_s1);

	// Stage 2: the two cross products of each edge function.
	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) begin
			for (int e = 0; e < 3; e++) begin
				p1_s2[e] <= qx_s1[e] * dy_s1[e];
				p2_s2[e] <= qy_s1[e] * dx_s1[e];
				dx_s2[e] <= dx_s1[e];
				dy_s2[e] <= dy_s1[e];
			end
			px0_s2   <= px0_s1;
			py0_s2   <= py0_s1;
			base_s2  <= base_full[ttc_pkg::BASE_W-1:0];
			color_s2 <= color_s1;
		end
	end

	// Stage 3: edge function values at the first pixel center.
	always_ff @(posedge clk) begin
		if (ctrl.ld_s3) begin
			for (int e = 0; e < 3; e++) begin
				e0_s3[e] <= EW'(p1_s2[e]) - EW'(p2_s2[e]);
				dx_s3[e] <= dx_s2[e];
				dy_s3[e] <= dy_s2[e];
			end
			px0_s3   <= px0_s2;
			py0_s3   <= py0_s2;
			base_s3  <= base_s2;
			color_s3 <= color_s2;
		end
	end

endmodule

// ===== hw/rtl/ttc_row_lane.sv =====
`timescale 1ns / 1ps

module ttc_row_lane #(
	parameter int TILE_SIDE = 8,
	parameter int FRAC_BITS = 4,
	parameter int ROW = 0,
	localparam int PXW = ttc_pkg::pix_w(TILE_SIDE),
	localparam int DW  = ttc_pkg::dist_w(PXW, FRAC_BITS),
	localparam int EW  = ttc_pkg::edge_w(DW)
) (
	input  logic signed [EW-1:0]              e0 [3],
	input  logic signed [ttc_pkg::DIFF_W-1:0] dx [3],
	input  logic signed [ttc_pkg::DIFF_W-1:0] dy [3],
	input  logic [PXW-1:0]                    px0,
	input  logic [PXW-1:0]                    py0,
	input  logic [ttc_pkg::SCREEN_W-1:0]      w_eff,
	input  logic [ttc_pkg::SCREEN_W-1:0]      h_eff,
	output logic [TILE_SIDE-1:0]              row_mask
);

	localparam int TW = ttc_pkg::DIFF_W + $clog2(TILE_SIDE) + 2;
	localparam int CW = ((PXW + 1 > ttc_pkg::SCREEN_W) ? PXW + 1 : ttc_pkg::SCREEN_W) + 1;

	logic                 row_on;
	logic                 col_on;
	logic                 hit;
	logic signed [TW-1:0] step;
	logic signed [EW-1:0] val;

	// One row of pixels: step each edge function across the row and clip to the screen.
	always_comb begin
		row_on = (CW'(py0) + CW'(ROW)) < CW'(h_eff);
		col_on = 1'b0;
		hit    = 1'b0;
		step   = '0;
		val    = '0;
		for (int c = 0; c < TILE_SIDE; c++) begin
			col_on = (CW'(px0) + CW'(c)) < CW'(w_eff);
			hit    = 1'b1;
			for (int e = 0; e < 3; e++) begin
				step = TW'(c) * TW'(dy[e]) - TW'(ROW) * TW'(dx[e]);
				val  = e0[e] + (EW'(step) <<< FRAC_BITS);
				hit  = hit & ~val[EW-1];
			end
			row_mask[c] = hit & row_on & col_on;
		end
	end

endmodule

// ===== hw/rtl/ttc_merge.sv =====
`timescale 1ns / 1ps

module ttc_merge #(
	parameter int TILE_SIDE = 8,
	localparam int NPIX = TILE_SIDE * TILE_SIDE
) (
	input  logic                         clk,
	input  ttc_pkg::pipe_ctrl_t          ctrl,
	input  logic [NPIX-1:0]              lane_mask,
	input  logic [ttc_pkg::BASE_W-1:0]   base_s3,
	input  logic [ttc_pkg::COLOR_W-1:0]  color_s3,
	output logic [NPIX-1:0]              coverage_mask,
	output logic [ttc_pkg::BASE_W-1:0]   base_index,
	output logic [ttc_pkg::COLOR_W-1:0]  packed_color,
	output logic                         any_covered
);

	logic [NPIX-1:0]             mask_s4;
	logic [ttc_pkg::BASE_W-1:0]  base_s4;
	logic [ttc_pkg::COLOR_W-1:0] color_s4;
	logic [NPIX-1:0]             mask_s5;
	logic [ttc_pkg::BASE_W-1:0]  base_s5;
	logic [ttc_pkg::COLOR_W-1:0] color_s5;
	logic                        any_s5;

	// Stage 4: capture the rows found by all lanes.
	always_ff @(posedge clk) begin
		if (ctrl.ld_s4) begin
			mask_s4  <= lane_mask;
			base_s4  <= base_s3;
			color_s4 <= color_s3;
		end
	end

	// Stage 5: output register with the combined coverage flag.
	always_ff @(posedge clk) begin
		if (ctrl.ld_s5) begin
			mask_s5  <= mask_s4;
			any_s5   <= |mask_s4;
			base_s5  <= base_s4;
			color_s5 <= color_s4;
		end
	end

	assign coverage_mask = mask_s5;
	assign base_index    = base_s5;
	assign packed_color  = color_s5;
	assign any_covered   = any_s5;

endmodule

// ===== hw/rtl/triangle_tile_coverage_core.sv =====
// Pipeline: each item passes through five register stages, s1 to s5, before its result is shown.
// Throughput: one item per cycle while in_stall is low; one row lane per tile row evaluates all
// pixels of a tile in a single stage, and the five-stage pipeline stalls only when full.
// Reset: clears every stage valid and sets screen_width to 640, screen_height to 480.
`timescale 1ns / 1ps
`include "triangle_tile_coverage_core_assert.svh"

module triangle_tile_coverage_core #(
	parameter int TILE_SIDE  = 8,
	parameter int MAX_SCREEN = 2048,
	parameter int FRAC_BITS  = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ttc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ttc_pkg::CFG_W-1:0]           cfg_data,
	// Input items.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [ttc_pkg::COORD_W-1:0]  v0_x,
	input  logic signed [ttc_pkg::COORD_W-1:0]  v0_y,
	input  logic signed [ttc_pkg::COORD_W-1:0]  v1_x,
	input  logic signed [ttc_pkg::COORD_W-1:0]  v1_y,
	input  logic signed [ttc_pkg::COORD_W-1:0]  v2_x,
	input  logic signed [ttc_pkg::COORD_W-1:0]  v2_y,
	input  logic [ttc_pkg::TILE_W-1:0]          tile_col,
	input  logic [ttc_pkg::TILE_W-1:0]          tile_row,
	input  logic [ttc_pkg::CHAN_W-1:0]          color_red,
	input  logic [ttc_pkg::CHAN_W-1:0]          color_green,
	input  logic [ttc_pkg::CHAN_W-1:0]          color_blue,
	// Result items.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [TILE_SIDE*TILE_SIDE-1:0]      coverage_mask,
	output logic [ttc_pkg::BASE_W-1:0]          base_index,
	output logic [ttc_pkg::COLOR_W-1:0]         packed_color,
	output logic                                any_covered
);

	localparam int PXW  = ttc_pkg::pix_w(TILE_SIDE);
	localparam int DW   = ttc_pkg::dist_w(PXW, FRAC_BITS);
	localparam int EW   = ttc_pkg::edge_w(DW);
	localparam int NPIX = TILE_SIDE * TILE_SIDE;

	logic [ttc_pkg::CFG_W-1:0]         screen_width_q;
	logic [ttc_pkg::CFG_W-1:0]         screen_height_q;
	logic [ttc_pkg::SCREEN_W-1:0]      w_eff, h_eff;

	logic                              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                              rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	ttc_pkg::pipe_ctrl_t               ctrl;

	logic signed [EW-1:0]              e0_s3 [3];
	logic signed [ttc_pkg::DIFF_W-1:0] dx_s3 [3];
	logic signed [ttc_pkg::DIFF_W-1:0] dy_s3 [3];
	logic [PXW-1:0]                    px0_s3, py0_s3;
	logic [ttc_pkg::BASE_W-1:0]        base_s3;
	logic [ttc_pkg::COLOR_W-1:0]       color_s3;
	logic [NPIX-1:0]                   lane_mask;

	// Configuration registers; writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= ttc_pkg::RST_SCREEN_WIDTH;
			screen_height_q <= ttc_pkg::RST_SCREEN_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ttc_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				ttc_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Screen size limited to the largest supported framebuffer.
	assign w_eff = (ttc_pkg::SCREEN_W'(screen_width_q) > ttc_pkg::SCREEN_W'(MAX_SCREEN)) ?
		ttc_pkg::SCREEN_W'(MAX_SCREEN) : ttc_pkg::SCREEN_W'(screen_width_q);
	assign h_eff = (ttc_pkg::SCREEN_W'(screen_height_q) > ttc_pkg::SCREEN_W'(MAX_SCREEN)) ?
		ttc_pkg::SCREEN_W'(MAX_SCREEN) : ttc_pkg::SCREEN_W'(screen_height_q);

	// Per-stage flow control: a stage loads when it is empty or its item moves on.
	assign rdy_s5 = !vld_s5 || !out_stall;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign ctrl.ld_s1 = rdy_s1;
	assign ctrl.ld_s2 = rdy_s2;
	assign ctrl.ld_s3 = rdy_s3;
	assign ctrl.ld_s4 = rdy_s4;
	assign ctrl.ld_s5 = rdy_s5;

	assign in_stall  = !rdy_s1;
	assign out_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// Edge setup: deltas, cross products and edge values at the first pixel center of the tile.
	ttc_setup #(
		.TILE_SIDE (TILE_SIDE),
		.FRAC_BITS (FRAC_BITS)
	) u_setup (
		.clk         (clk),
		.ctrl        (ctrl),
		.v0_x        (v0_x),
		.v0_y        (v0_y),
		.v1_x        (v1_x),
		.v1_y        (v1_y),
		.v2_x        (v2_x),
		.v2_y        (v2_y),
		.tile_col    (tile_col),
		.tile_row    (tile_row),
		.color_red   (color_red),
		.color_green (color_green),
		.color_blue  (color_blue),
		.w_eff       (w_eff),
		.e0_s3       (e0_s3),
		.dx_s3       (dx_s3),
		.dy_s3       (dy_s3),
		.px0_s3      (px0_s3),
		.py0_s3      (py0_s3),
		.base_s3     (base_s3),
		.color_s3    (color_s3)
	);

	// One lane per tile row.
	for (genvar r = 0; r < TILE_SIDE; r++) begin : g_lane
		ttc_row_lane #(
			.TILE_SIDE (TILE_SIDE),
			.FRAC_BITS (FRAC_BITS),
			.ROW       (r)
		) u_lane (
			.e0       (e0_s3),
			.dx       (dx_s3),
			.dy       (dy_s3),
			.px0      (px0_s3),
			.py0      (py0_s3),
			.w_eff    (w_eff),
			.h_eff    (h_eff),
			.row_mask (lane_mask[r*TILE_SIDE +: TILE_SIDE])
		);
	end

	// Merge of the lane rows and output register.
	ttc_merge #(
		.TILE_SIDE (TILE_SIDE)
	) u_merge (
		.clk           (clk),
		.ctrl          (ctrl),
		.lane_mask     (lane_mask),
		.base_s3       (base_s3),
		.color_s3      (color_s3),
		.coverage_mask (coverage_mask),
		.base_index    (base_index),
		.packed_color  (packed_color),
		.any_covered   (any_covered)
	);

	// The coverage flag agrees with the mask it was derived from.
	`TTC_ASSERT_ALWAYS(a_any_matches_mask, !out_valid || (any_covered == (coverage_mask != '0)), "any_covered disagrees with coverage_mask")
	// Input is held off only when every stage is occupied and the output is stalled.
	`TTC_ASSERT_ALWAYS(a_stall_only_full, !in_stall || (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && out_stall), "input stalled while the pipeline has room")
	// A delivered result with nothing behind it leaves the output empty.
	`TTC_ASSERT_NEXT(a_no_repeat, out_valid && !out_stall && !vld_s4, !out_valid, "result repeated after delivery")

endmodule
